// ===== hdl/aceq_pkg.sv =====
// ----------------------------------------------------------------------------
// aceq_pkg
// Shared widths, codes and types of the adaptive complex equalizer.
// ----------------------------------------------------------------------------
package aceq_pkg;

    // Default number of taps
    localparam int TAPS_DEF   = 16;

    // Field widths
    localparam int SMP_W      = 16;            // Q2.13 sample, pivot, output
    localparam int TAP_W      = 24;            // Q3.20 tap part
    localparam int ERR_W      = 24;            // error part, Q.13
    localparam int STEP_W     = 17;            // widest step register
    localparam int MOD_W      = 20;            // Q4.16 modulus
    localparam int PM_W       = 40;            // one tap by sample product
    localparam int PROD_W     = PM_W + 1;      // conj(e) * hist part
    localparam int SCL_W      = PROD_W + STEP_W + 1;
    localparam int DW         = SCL_W + 4;     // signed increment width
    localparam int NUM_W      = DW - 1;        // divider dividend width
    localparam int POW_BASE_W = 32;            // one history power term
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic signed [TAP_W-1:0] TAP_ONE = 24'sd1048576;

    // Adaptation modes
    typedef enum logic [1:0] {
        MODE_LMS  = 2'd0,
        MODE_NLMS = 2'd1,
        MODE_CMA  = 2'd2,
        MODE_MMA  = 2'd3
    } t_mode;

    // Register indexes
    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_BLIND_STEP = 3'd1,
        REG_DD_STEP    = 3'd2,
        REG_NLMS_STEP  = 3'd3,
        REG_CMA_MOD    = 3'd4,
        REG_MMA_RE_MOD = 3'd5,
        REG_MMA_IM_MOD = 3'd6
    } t_reg;

    // Configuration bundle
    typedef struct packed {
        t_mode              mode;
        logic [15:0]        blind_step;
        logic [15:0]        dd_step;
        logic [STEP_W-1:0]  nlms_step;
        logic [MOD_W-1:0]   cma_mod;
        logic [MOD_W-1:0]   mma_re_mod;
        logic [MOD_W-1:0]   mma_im_mod;
    } t_cfg;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD,
        OP_FMUL,
        OP_FACC,
        OP_FOUT,
        OP_ESQ,
        OP_EDIFF,
        OP_EFIN,
        OP_PMUL,
        OP_PACC,
        OP_TMUL,
        OP_TSUM,
        OP_TSCL,
        OP_TRND,
        OP_DNUM,
        OP_DGO,
        OP_DQUO,
        OP_TWR,
        OP_EMIT
    } t_op;

    // Controller to datapath
    typedef struct packed {
        t_op  op;
        logic k_clr;
        logic k_inc;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic upd;
        logic nlms;
        logic dd;
        logic y_zero;
        logic last;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/aceq_if.sv =====
// ----------------------------------------------------------------------------
// aceq_in_if / aceq_out_if
// Valid/ready channels carrying equalizer input and result beats.
// ----------------------------------------------------------------------------
interface aceq_in_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [15:0]       sample_re;
    logic signed [15:0]       sample_im;
    logic signed [15:0]       pivot_re;
    logic signed [15:0]       pivot_im;

    modport source (output valid, cmd, sample_re, sample_im, pivot_re, pivot_im,
                    input ready);
    modport sink   (input valid, cmd, sample_re, sample_im, pivot_re, pivot_im,
                    output ready);
endinterface

interface aceq_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       out_re;
    logic signed [15:0]       out_im;
    logic                     saturated;

    modport source (output valid, out_re, out_im, saturated, input ready);
    modport sink   (input valid, out_re, out_im, saturated, output ready);
endinterface

// ===== hdl/aceq_regs.sv =====
// ----------------------------------------------------------------------------
// aceq_regs
// APB register file holding mode, step sizes and modulus constants.
// ----------------------------------------------------------------------------
module aceq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aceq_pkg::ADDR_W-1:0]   paddr,
    input  logic [aceq_pkg::DATA_W-1:0]   pwdata,
    output logic [aceq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output aceq_pkg::t_cfg                o_cfg
);

    aceq_pkg::t_cfg r_cfg;
    aceq_pkg::t_reg reg_sel;
    logic           wr_en;

    assign reg_sel = aceq_pkg::t_reg'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write registers on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= aceq_pkg::MODE_LMS;
            r_cfg.blind_step <= 16'd16;
            r_cfg.dd_step    <= 16'd256;
            r_cfg.nlms_step  <= 17'd6554;
            r_cfg.cma_mod    <= 20'd65536;
            r_cfg.mma_re_mod <= 20'd65536;
            r_cfg.mma_im_mod <= 20'd65536;
        end else if (wr_en) begin
            case (reg_sel)
                aceq_pkg::REG_MODE:       r_cfg.mode <= aceq_pkg::t_mode'(pwdata[1:0]);
                aceq_pkg::REG_BLIND_STEP: r_cfg.blind_step <= pwdata[15:0];
                aceq_pkg::REG_DD_STEP:    r_cfg.dd_step <= pwdata[15:0];
                aceq_pkg::REG_NLMS_STEP:  r_cfg.nlms_step <= pwdata[16:0];
                aceq_pkg::REG_CMA_MOD:    r_cfg.cma_mod <= pwdata[19:0];
                aceq_pkg::REG_MMA_RE_MOD: r_cfg.mma_re_mod <= pwdata[19:0];
                aceq_pkg::REG_MMA_IM_MOD: r_cfg.mma_im_mod <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (reg_sel)
            aceq_pkg::REG_MODE:       prdata = 32'(r_cfg.mode);
            aceq_pkg::REG_BLIND_STEP: prdata = 32'(r_cfg.blind_step);
            aceq_pkg::REG_DD_STEP:    prdata = 32'(r_cfg.dd_step);
            aceq_pkg::REG_NLMS_STEP:  prdata = 32'(r_cfg.nlms_step);
            aceq_pkg::REG_CMA_MOD:    prdata = 32'(r_cfg.cma_mod);
            aceq_pkg::REG_MMA_RE_MOD: prdata = 32'(r_cfg.mma_re_mod);
            aceq_pkg::REG_MMA_IM_MOD: prdata = 32'(r_cfg.mma_im_mod);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== hdl/aceq_div.sv =====
// ----------------------------------------------------------------------------
// aceq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aceq_div #(
    parameter int DVW = aceq_pkg::POW_BASE_W + $clog2(aceq_pkg::TAPS_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [aceq_pkg::NUM_W-1:0]   i_num,
    input  logic [DVW-1:0]               i_den,
    output logic                         o_busy,
    output logic [aceq_pkg::NUM_W-1:0]   o_quo
);

    localparam int NW = aceq_pkg::NUM_W;
    localparam int CW = $clog2(NW + 1);

    logic           r_busy;
    logic [CW-1:0]  r_cnt;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_den;
    logic [NW-1:0]  r_quo;
    logic [DVW:0]   rem_sh;
    logic [DVW:0]   rem_sub;
    logic           ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/aceq_dp.sv =====
// ----------------------------------------------------------------------------
// aceq_dp
// Equalizer datapath: tap and history memories, shared multipliers,
// accumulators, error unit, NLMS dividers and the result register.
// ----------------------------------------------------------------------------
module aceq_dp #(
    parameter int TAPS = aceq_pkg::TAPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  aceq_pkg::t_cmd                       i_cmd,
    output aceq_pkg::t_stat                      o_st,
    input  aceq_pkg::t_cfg                       i_cfg,
    input  logic                                 i_in_cmd,
    input  logic signed [aceq_pkg::SMP_W-1:0]    i_sample_re,
    input  logic signed [aceq_pkg::SMP_W-1:0]    i_sample_im,
    input  logic signed [aceq_pkg::SMP_W-1:0]    i_pivot_re,
    input  logic signed [aceq_pkg::SMP_W-1:0]    i_pivot_im,
    output logic                                 o_out_vld,
    input  logic                                 i_out_rdy,
    output logic signed [aceq_pkg::SMP_W-1:0]    o_out_re,
    output logic signed [aceq_pkg::SMP_W-1:0]    o_out_im,
    output logic                                 o_out_sat
);

    localparam int IW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int AW     = aceq_pkg::PROD_W + $clog2(TAPS);
    localparam int PW     = aceq_pkg::POW_BASE_W + $clog2(TAPS);
    localparam int CTR    = TAPS / 2;
    localparam int SW     = aceq_pkg::SMP_W;
    localparam int TW     = aceq_pkg::TAP_W;
    localparam int EW     = aceq_pkg::ERR_W;
    localparam int MW     = aceq_pkg::PM_W;
    localparam int PRW    = aceq_pkg::PROD_W;
    localparam int SCW    = aceq_pkg::SCL_W;
    localparam int DW     = aceq_pkg::DW;
    localparam int NW     = aceq_pkg::NUM_W;
    localparam int QW     = 34;            // blind error numerator
    localparam int BW     = QW + SW;       // blind error product

    // Memories and their valid bits
    logic [2*TW-1:0]  mem_tap  [TAPS];
    logic [2*SW-1:0]  mem_hist [TAPS];
    logic [TAPS-1:0]  r_tvld;
    logic [TAPS-1:0]  r_hvld;
    logic [2*TW-1:0]  r_tq;
    logic             r_tq_vld;
    logic             r_tq_ctr;
    logic [2*SW-1:0]  r_hq;
    logic             r_hq_vld;

    // Item state
    logic                   r_upd;
    logic signed [SW-1:0]   r_pre, r_pim;
    logic signed [SW-1:0]   r_yre, r_yim;
    logic                   r_sat;
    logic [IW-1:0]          r_k, r_rp, r_wp, wp_dec;

    // Working registers
    logic signed [MW-1:0]   r_m0, r_m1, r_m2, r_m3;
    logic signed [AW-1:0]   r_accr, r_acci;
    logic signed [QW-1:0]   r_err_r, r_err_i;
    logic signed [EW-1:0]   r_er, r_ei;
    logic [PW-1:0]          r_pow;
    logic signed [PRW-1:0]  r_pr, r_pi;
    logic signed [SCW-1:0]  r_sr, r_si;
    logic [NW-1:0]          r_numr, r_numi;
    logic                   r_negr, r_negi;
    logic signed [DW-1:0]   r_dr, r_di;

    // Output register
    logic                   r_ovld;
    logic signed [SW-1:0]   r_ore, r_oim;
    logic                   r_osat;

    // Combinational helpers
    logic signed [TW-1:0]   tre, tim;
    logic signed [SW-1:0]   hre, him;
    logic signed [MW-1:0]   tre_x, tim_x, hre_x, him_x, er_x, ei_x, yre_x, yim_x;
    logic signed [AW:0]     yr_sh, yi_sh;
    logic                   yr_hi, yr_lo, yi_hi, yi_lo;
    logic signed [QW-1:0]   mod_c, mod_r, mod_i;
    logic signed [BW-1:0]   berr_r, berr_i;
    logic signed [SW:0]     dd_r, dd_i;
    logic [aceq_pkg::STEP_W-1:0] step;
    logic signed [SCW-1:0]  step_x, pr_x, pi_x, sr_rnd, si_rnd;
    logic [PW-1:0]          den;
    logic signed [DW-1:0]   numr_s, numi_s, half_s;
    logic signed [DW-1:0]   magr, magi;
    logic                   divr_busy, divi_busy;
    logic [NW-1:0]          quor, quoi;
    logic signed [DW:0]     tsum_r, tsum_i;
    logic                   tr_hi, tr_lo, ti_hi, ti_lo;
    logic signed [TW-1:0]   tnew_r, tnew_i;
    logic                   div_go;
    logic                   is_blind;

    // Effective memory words (unwritten entries read as their reset value)
    always_comb begin
        tre = r_tq_vld ? $signed(r_tq[2*TW-1:TW])
                       : (r_tq_ctr ? aceq_pkg::TAP_ONE : '0);
        tim = r_tq_vld ? $signed(r_tq[TW-1:0]) : '0;
        hre = r_hq_vld ? $signed(r_hq[2*SW-1:SW]) : '0;
        him = r_hq_vld ? $signed(r_hq[SW-1:0]) : '0;
        tre_x = MW'(tre);
        tim_x = MW'(tim);
        hre_x = MW'(hre);
        him_x = MW'(him);
        er_x  = MW'(r_er);
        ei_x  = MW'(r_ei);
        yre_x = MW'(r_yre);
        yim_x = MW'(r_yim);
    end

    assign wp_dec   = (r_wp == '0) ? IW'(TAPS - 1) : r_wp - 1'b1;
    assign is_blind = i_cfg.mode[1];

    // Output rounding and clipping
    always_comb begin
        yr_sh = ($signed({r_accr[AW-1], r_accr}) + (AW+1)'(524288)) >>> 20;
        yi_sh = ($signed({r_acci[AW-1], r_acci}) + (AW+1)'(524288)) >>> 20;
        yr_hi = yr_sh > (AW+1)'(32767);
        yr_lo = yr_sh < (AW+1)'(-32768);
        yi_hi = yi_sh > (AW+1)'(32767);
        yi_lo = yi_sh < (AW+1)'(-32768);
    end

    // Error terms
    always_comb begin
        mod_c  = $signed({4'b0, i_cfg.cma_mod, 10'b0});
        mod_r  = $signed({4'b0, i_cfg.mma_re_mod, 10'b0});
        mod_i  = $signed({4'b0, i_cfg.mma_im_mod, 10'b0});
        berr_r = BW'(r_err_r) * BW'(r_yre) + BW'(33554432);
        berr_i = BW'(r_err_i) * BW'(r_yim) + BW'(33554432);
        dd_r   = (SW+1)'(r_pre) - (SW+1)'(r_yre);
        dd_i   = (SW+1)'(r_pim) - (SW+1)'(r_yim);
    end

    // Step selection and scaling
    always_comb begin
        if (i_cfg.mode == aceq_pkg::MODE_NLMS) begin
            step = i_cfg.nlms_step;
        end else if (is_blind) begin
            step = {1'b0, i_cfg.blind_step};
        end else begin
            step = {1'b0, i_cfg.dd_step};
        end
        step_x = $signed(SCW'(step));
        pr_x   = SCW'(r_pr);
        pi_x   = SCW'(r_pi);
        sr_rnd = r_sr + SCW'(536870912);
        si_rnd = r_si + SCW'(536870912);
    end

    // NLMS dividend magnitude plus half divisor
    always_comb begin
        den    = (r_pow == '0) ? PW'(1) : r_pow;
        half_s = $signed(DW'(den >> 1));
        numr_s = {r_sr, 4'b0};
        numi_s = {r_si, 4'b0};
        magr   = r_sr[SCW-1] ? (~numr_s + half_s + DW'(1)) : (numr_s + half_s);
        magi   = r_si[SCW-1] ? (~numi_s + half_s + DW'(1)) : (numi_s + half_s);
    end

    // Tap accumulate and clip
    always_comb begin
        tsum_r = (DW+1)'(tre) + (DW+1)'(r_dr);
        tsum_i = (DW+1)'(tim) + (DW+1)'(r_di);
        tr_hi  = tsum_r > (DW+1)'(8388607);
        tr_lo  = tsum_r < (DW+1)'(-8388608);
        ti_hi  = tsum_i > (DW+1)'(8388607);
        ti_lo  = tsum_i < (DW+1)'(-8388608);
        tnew_r = tr_hi ? TW'(8388607) : (tr_lo ? TW'(-8388608) : tsum_r[TW-1:0]);
        tnew_i = ti_hi ? TW'(8388607) : (ti_lo ? TW'(-8388608) : tsum_i[TW-1:0]);
    end

    assign div_go = (i_cmd.op == aceq_pkg::OP_DGO);

    aceq_div #(.DVW(PW)) u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_numr),
        .i_den   (den),
        .o_busy  (divr_busy),
        .o_quo   (quor)
    );

    aceq_div #(.DVW(PW)) u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_numi),
        .i_den   (den),
        .o_busy  (divi_busy),
        .o_quo   (quoi)
    );

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == aceq_pkg::OP_LOAD && !i_in_cmd) begin
            mem_hist[wp_dec] <= {i_sample_re, i_sample_im};
        end
        if (i_cmd.op == aceq_pkg::OP_TWR) begin
            mem_tap[r_k] <= {tnew_r, tnew_i};
        end
        if (i_cmd.op == aceq_pkg::OP_RD) begin
            r_tq <= mem_tap[r_k];
            r_hq <= mem_hist[r_rp];
        end
    end

    // Control state: valid bits, pointers, output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld   <= '0;
            r_hvld   <= '0;
            r_tq_vld <= 1'b0;
            r_tq_ctr <= 1'b0;
            r_hq_vld <= 1'b0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_k      <= '0;
            r_upd    <= 1'b0;
            r_yre    <= '0;
            r_yim    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cmd.op == aceq_pkg::OP_LOAD) begin
                r_upd <= i_in_cmd;
                if (!i_in_cmd) begin
                    r_wp           <= wp_dec;
                    r_hvld[wp_dec] <= 1'b1;
                end
            end
            if (i_cmd.op == aceq_pkg::OP_RD) begin
                r_tq_vld <= r_tvld[r_k];
                r_tq_ctr <= (r_k == IW'(CTR));
                r_hq_vld <= r_hvld[r_rp];
            end
            if (i_cmd.op == aceq_pkg::OP_TWR) begin
                r_tvld[r_k] <= 1'b1;
            end
            if (i_cmd.op == aceq_pkg::OP_FOUT) begin
                r_yre <= yr_hi ? SW'(32767) : (yr_lo ? SW'(-32768) : yr_sh[SW-1:0]);
                r_yim <= yi_hi ? SW'(32767) : (yi_lo ? SW'(-32768) : yi_sh[SW-1:0]);
            end
            // Advance the tap index and the history read pointer together
            if (i_cmd.k_clr) begin
                r_k  <= '0;
                r_rp <= r_wp;
            end else if (i_cmd.k_inc) begin
                r_k  <= (r_k == IW'(TAPS - 1)) ? '0 : r_k + 1'b1;
                r_rp <= (r_rp == IW'(TAPS - 1)) ? '0 : r_rp + 1'b1;
            end
            // Hold the result beat until taken
            if (i_cmd.op == aceq_pkg::OP_EMIT) begin
                r_ovld <= 1'b1;
            end else if (i_out_rdy) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            aceq_pkg::OP_LOAD: begin
                r_pre  <= i_pivot_re;
                r_pim  <= i_pivot_im;
                r_sat  <= 1'b0;
                r_accr <= '0;
                r_acci <= '0;
                r_pow  <= '0;
            end
            aceq_pkg::OP_FMUL: begin
                r_m0 <= tre_x * hre_x;
                r_m1 <= tim_x * him_x;
                r_m2 <= tre_x * him_x;
                r_m3 <= tim_x * hre_x;
            end
            aceq_pkg::OP_FACC: begin
                r_accr <= r_accr + AW'(r_m0) + AW'(r_m1);
                r_acci <= r_acci + AW'(r_m2) - AW'(r_m3);
            end
            aceq_pkg::OP_FOUT: begin
                r_sat <= yr_hi | yr_lo | yi_hi | yi_lo;
            end
            aceq_pkg::OP_ESQ: begin
                r_m0 <= yre_x * yre_x;
                r_m1 <= yim_x * yim_x;
            end
            aceq_pkg::OP_EDIFF: begin
                if (i_cfg.mode == aceq_pkg::MODE_CMA) begin
                    r_err_r <= mod_c - $signed(r_m0[QW-1:0]) - $signed(r_m1[QW-1:0]);
                    r_err_i <= mod_c - $signed(r_m0[QW-1:0]) - $signed(r_m1[QW-1:0]);
                end else begin
                    r_err_r <= mod_r - $signed(r_m0[QW-1:0]);
                    r_err_i <= mod_i - $signed(r_m1[QW-1:0]);
                end
            end
            aceq_pkg::OP_EFIN: begin
                if (is_blind) begin
                    r_er <= berr_r[BW-1:26];
                    r_ei <= berr_i[BW-1:26];
                end else begin
                    r_er <= EW'(dd_r);
                    r_ei <= EW'(dd_i);
                end
            end
            aceq_pkg::OP_PMUL: begin
                r_m0 <= hre_x * hre_x;
                r_m1 <= him_x * him_x;
            end
            aceq_pkg::OP_PACC: begin
                r_pow <= r_pow + PW'(r_m0[31:0]) + PW'(r_m1[31:0]);
            end
            aceq_pkg::OP_TMUL: begin
                r_m0 <= hre_x * er_x;
                r_m1 <= him_x * ei_x;
                r_m2 <= him_x * er_x;
                r_m3 <= hre_x * ei_x;
            end
            aceq_pkg::OP_TSUM: begin
                r_pr <= PRW'(r_m0) + PRW'(r_m1);
                r_pi <= PRW'(r_m2) - PRW'(r_m3);
            end
            aceq_pkg::OP_TSCL: begin
                r_sr <= pr_x * step_x;
                r_si <= pi_x * step_x;
            end
            aceq_pkg::OP_TRND: begin
                r_dr <= {{(DW-(SCW-30)){sr_rnd[SCW-1]}}, sr_rnd[SCW-1:30]};
                r_di <= {{(DW-(SCW-30)){si_rnd[SCW-1]}}, si_rnd[SCW-1:30]};
            end
            aceq_pkg::OP_DNUM: begin
                r_numr <= magr[NW-1:0];
                r_numi <= magi[NW-1:0];
                r_negr <= r_sr[SCW-1];
                r_negi <= r_si[SCW-1];
            end
            aceq_pkg::OP_DQUO: begin
                r_dr <= r_negr ? -$signed({1'b0, quor}) : $signed({1'b0, quor});
                r_di <= r_negi ? -$signed({1'b0, quoi}) : $signed({1'b0, quoi});
            end
            aceq_pkg::OP_TWR: begin
                r_sat <= r_sat | tr_hi | tr_lo | ti_hi | ti_lo;
            end
            aceq_pkg::OP_EMIT: begin
                r_ore  <= r_yre;
                r_oim  <= r_yim;
                r_osat <= r_sat;
            end
            default: ;
        endcase
    end

    // Status to the controller
    always_comb begin
        o_st.upd      = r_upd;
        o_st.nlms     = (i_cfg.mode == aceq_pkg::MODE_NLMS);
        o_st.dd       = !is_blind;
        o_st.y_zero   = (r_yre == '0) && (r_yim == '0);
        o_st.last     = (r_k == IW'(TAPS - 1));
        o_st.div_busy = divr_busy | divi_busy;
        o_st.out_free = !r_ovld || i_out_rdy;
    end

    assign o_out_vld = r_ovld;
    assign o_out_re  = r_ore;
    assign o_out_im  = r_oim;
    assign o_out_sat = r_osat;

endmodule

// ===== hdl/aceq_ctrl.sv =====
// ----------------------------------------------------------------------------
// aceq_ctrl
// Sequencer: steps the datapath through the filter pass or the tap update.
// ----------------------------------------------------------------------------
module aceq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_vld,
    output logic             o_in_rdy,
    input  aceq_pkg::t_stat  i_st,
    output aceq_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_F_RD,
        S_F_MUL,
        S_F_ACC,
        S_F_OUT,
        S_E_SQ,
        S_E_DIFF,
        S_E_FIN,
        S_P_RD,
        S_P_MUL,
        S_P_ACC,
        S_T_RD,
        S_T_MUL,
        S_T_SUM,
        S_T_SCL,
        S_T_RND,
        S_T_DNUM,
        S_T_DGO,
        S_T_WAIT,
        S_T_QUO,
        S_T_WR,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath command
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = aceq_pkg::OP_NONE;
        o_cmd.k_clr = 1'b0;
        o_cmd.k_inc = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_vld) begin
                    o_cmd.op = aceq_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.k_clr = 1'b1;
                n_state     = i_st.upd ? S_E_SQ : S_F_RD;
            end
            // Filter pass
            S_F_RD: begin
                o_cmd.op = aceq_pkg::OP_RD;
                n_state  = S_F_MUL;
            end
            S_F_MUL: begin
                o_cmd.op = aceq_pkg::OP_FMUL;
                n_state  = S_F_ACC;
            end
            S_F_ACC: begin
                o_cmd.op    = aceq_pkg::OP_FACC;
                o_cmd.k_inc = 1'b1;
                n_state     = i_st.last ? S_F_OUT : S_F_RD;
            end
            S_F_OUT: begin
                o_cmd.op = aceq_pkg::OP_FOUT;
                n_state  = S_FIN;
            end
            // Error
            S_E_SQ: begin
                o_cmd.op = aceq_pkg::OP_ESQ;
                n_state  = S_E_DIFF;
            end
            S_E_DIFF: begin
                o_cmd.op = aceq_pkg::OP_EDIFF;
                n_state  = S_E_FIN;
            end
            S_E_FIN: begin
                o_cmd.op = aceq_pkg::OP_EFIN;
                if (i_st.dd && i_st.y_zero) begin
                    n_state = S_FIN;
                end else if (i_st.nlms) begin
                    n_state = S_P_RD;
                end else begin
                    n_state = S_T_RD;
                end
            end
            // History power
            S_P_RD: begin
                o_cmd.op = aceq_pkg::OP_RD;
                n_state  = S_P_MUL;
            end
            S_P_MUL: begin
                o_cmd.op = aceq_pkg::OP_PMUL;
                n_state  = S_P_ACC;
            end
            S_P_ACC: begin
                o_cmd.op = aceq_pkg::OP_PACC;
                if (i_st.last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_T_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_P_RD;
                end
            end
            // Tap update
            S_T_RD: begin
                o_cmd.op = aceq_pkg::OP_RD;
                n_state  = S_T_MUL;
            end
            S_T_MUL: begin
                o_cmd.op = aceq_pkg::OP_TMUL;
                n_state  = S_T_SUM;
            end
            S_T_SUM: begin
                o_cmd.op = aceq_pkg::OP_TSUM;
                n_state  = S_T_SCL;
            end
            S_T_SCL: begin
                o_cmd.op = aceq_pkg::OP_TSCL;
                n_state  = i_st.nlms ? S_T_DNUM : S_T_RND;
            end
            S_T_RND: begin
                o_cmd.op = aceq_pkg::OP_TRND;
                n_state  = S_T_WR;
            end
            S_T_DNUM: begin
                o_cmd.op = aceq_pkg::OP_DNUM;
                n_state  = S_T_DGO;
            end
            S_T_DGO: begin
                o_cmd.op = aceq_pkg::OP_DGO;
                n_state  = S_T_WAIT;
            end
            S_T_WAIT: begin
                if (!i_st.div_busy) begin
                    n_state = S_T_QUO;
                end
            end
            S_T_QUO: begin
                o_cmd.op = aceq_pkg::OP_DQUO;
                n_state  = S_T_WR;
            end
            S_T_WR: begin
                o_cmd.op    = aceq_pkg::OP_TWR;
                o_cmd.k_inc = 1'b1;
                n_state     = i_st.last ? S_FIN : S_T_RD;
            end
            // Hand the result to the output register
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.op = aceq_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_rdy = (r_state == S_IDLE);

endmodule

// ===== hdl/adaptive_complex_equalizer.sv =====
// ----------------------------------------------------------------------------
// adaptive_complex_equalizer
// Complex adaptive FIR equalizer with LMS, NLMS, CMA and MMA tap adaptation.
// ----------------------------------------------------------------------------
// Each beat on i_in gives exactly one beat on o_out. In a filter beat (cmd 0)
// one shared complex multiply-accumulate unit visits the taps one at a time.
// An update beat computes the error and then updates every tap in LMS, CMA
// and MMA; in NLMS it first sums the history power, and each tap update also
// waits for the bit-serial dividers. A decision-mode update with a zero last
// output finishes after the error stage. A finished result sits in an output
// register, so the next beat is taken while it waits. Taps and history need
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module adaptive_complex_equalizer #(
    parameter int TAPS = aceq_pkg::TAPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aceq_in_if.sink                       i_in,
    aceq_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aceq_pkg::ADDR_W-1:0]   paddr,
    input  logic [aceq_pkg::DATA_W-1:0]   pwdata,
    output logic [aceq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    aceq_pkg::t_cfg  cfg;
    aceq_pkg::t_cmd  cmd;
    aceq_pkg::t_stat st;
    logic            in_rdy;
    logic            out_vld;
    logic signed [aceq_pkg::SMP_W-1:0] out_re, out_im;
    logic            out_sat;

    aceq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aceq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_vld (i_in.valid),
        .o_in_rdy (in_rdy),
        .i_st     (st),
        .o_cmd    (cmd)
    );

    aceq_dp #(.TAPS(TAPS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cfg       (cfg),
        .i_in_cmd    (i_in.cmd),
        .i_sample_re (i_in.sample_re),
        .i_sample_im (i_in.sample_im),
        .i_pivot_re  (i_in.pivot_re),
        .i_pivot_im  (i_in.pivot_im),
        .o_out_vld   (out_vld),
        .i_out_rdy   (o_out.ready),
        .o_out_re    (out_re),
        .o_out_im    (out_im),
        .o_out_sat   (out_sat)
    );

    // Drive the channels
    assign i_in.ready      = in_rdy;
    assign o_out.valid     = out_vld;
    assign o_out.out_re    = out_re;
    assign o_out.out_im    = out_im;
    assign o_out.saturated = out_sat;

endmodule
